@@ src/bpc_pkg.sv @@
// Shared types and constants for the barometric pressure compensation pipeline.
// No dependencies; imported by the top level.
package bpc_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_AC1 = 3'd0;
  localparam logic [2:0] REG_AC2 = 3'd1;
  localparam logic [2:0] REG_AC3 = 3'd2;
  localparam logic [2:0] REG_AC4 = 3'd3;
  localparam logic [2:0] REG_AC5 = 3'd4;
  localparam logic [2:0] REG_AC6 = 3'd5;
  localparam logic [2:0] REG_MC  = 3'd6;
  localparam logic [2:0] REG_MD  = 3'd7;

  // Temperature divider: |mc*2048| over |x1+md|
  localparam int D1_W     = 27;
  localparam int D1_DW    = 18;
  localparam int D1_STEPS = 27;

  // Pressure divider: |b7| or |2*b7| over b4, quotient capped at 22 bits
  localparam int D2_W     = 53;
  localparam int D2_DW    = 44;
  localparam int D2_STEPS = 22;

  // Total register stages from input to output register
  localparam int NSTG = 3 + D1_STEPS + 9 + D2_STEPS + 4;

  typedef struct packed {
    logic [D1_W-1:0]  r;
    logic [D1_W-1:0]  q;
    logic [D1_DW-1:0] d;
    logic             neg;
    logic [17:0]      x1;
    logic [18:0]      up;
    logic             fault;
  } div1_t;

  typedef struct packed {
    logic [D2_W-1:0]  r;
    logic [D2_STEPS-1:0] q;
    logic [D2_DW-1:0] d;
    logic             sat;
    logic             neg;
    logic             caseb;
    logic [15:0]      t;
    logic             fault;
  } div2_t;

endpackage

@@ src/barometric_pressure_compensation.sv @@
// Barometric pressure compensation: one reading in, temperature and pressure out.
// Depends on bpc_pkg for register codes, divider sizes and stage structs.
//
// Takes a raw temperature and a raw pressure (oversampling 3) and returns the
// compensated temperature in 0.1 degC and pressure in Pa, with a fault flag
// when a divisor is zero or the sensitivity term is not positive (both
// results are then zero). A new reading is taken every cycle unless a
// finished result waits on the output, which holds the whole pipeline. Two
// restoring dividers retire one quotient bit per stage (27 stages for the
// temperature term, 22 for the pressure term). Coefficients are read live,
// not latched per reading, so write them only while the pipeline is empty.
module barometric_pressure_compensation
  import bpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [15:0] raw_temperature, [34:16] raw_pressure
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [15:0] temperature_decicelsius,
                                 // [35:16] pressure_pascal, [36] divide_fault
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic signed [13:0] C_P1 = -14'sd7357;

  // Calibration registers
  logic signed [15:0] ac1, ac2, ac3, mc, md;
  logic        [15:0] ac4, ac5, ac6;

  always_ff @(posedge clk) begin
    if (rst) begin
      ac1 <= 16'sd408;
      ac2 <= -16'sd72;
      ac3 <= -16'sd14383;
      ac4 <= 16'd32741;
      ac5 <= 16'd32757;
      ac6 <= 16'd23153;
      mc  <= -16'sd8711;
      md  <= 16'sd2868;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AC1: ac1 <= cfg_data;
        REG_AC2: ac2 <= cfg_data;
        REG_AC3: ac3 <= cfg_data;
        REG_AC4: ac4 <= cfg_data;
        REG_AC5: ac5 <= cfg_data;
        REG_AC6: ac6 <= cfg_data;
        REG_MC:  mc  <= cfg_data;
        REG_MD:  md  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Flow control: the pipeline moves as a whole when the output is free
  logic            adv;
  logic [NSTG-1:0] vld;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], s_tvalid};
    end
  end

  // Stage 0: input capture
  logic [15:0] s0_ut;
  logic [18:0] s0_up;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_ut <= s_tdata[15:0];
      s0_up <= s_tdata[34:16];
    end
  end

  // Stage 1: (ut - ac6) * ac5
  logic signed [16:0] t_diff;
  logic signed [33:0] s1_p;
  logic        [18:0] s1_up;

  assign t_diff = $signed({1'b0, s0_ut}) - $signed({1'b0, ac6});

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_p  <= t_diff * $signed({1'b0, ac5});
      s1_up <= s0_up;
    end
  end

  // Stage 2: x1 and the temperature divisor x1 + md
  logic signed [17:0] x1_w;
  logic signed [18:0] den;
  logic signed [18:0] den_neg;
  logic signed [17:0] s2_x1;
  logic        [17:0] s2_dabs;
  logic               s2_dneg;
  logic               s2_fault;
  logic        [18:0] s2_up;

  assign x1_w    = s1_p[32:15];
  assign den     = 19'(x1_w) + 19'(md);
  assign den_neg = -den;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_x1    <= x1_w;
      s2_dabs  <= den[18] ? den_neg[17:0] : den[17:0];
      s2_dneg  <= den[18];
      s2_fault <= (den == 19'sd0);
      s2_up    <= s1_up;
    end
  end

  // Temperature divider input: |mc| * 2048
  logic [15:0] mc_u;
  logic [15:0] mc_abs;
  div1_t       d1_in;

  assign mc_u   = mc;
  assign mc_abs = mc_u[15] ? (~mc_u + 16'd1) : mc_u;

  always_comb begin
    d1_in       = '0;
    d1_in.r     = {mc_abs, 11'b0};
    d1_in.d     = s2_dabs;
    d1_in.neg   = mc_u[15] ^ s2_dneg;
    d1_in.x1    = s2_x1;
    d1_in.up    = s2_up;
    d1_in.fault = s2_fault;
  end

  // Temperature divider: one quotient bit per stage, MSB first
  div1_t d1     [D1_STEPS];
  div1_t d1_src [D1_STEPS];

  for (genvar j = 0; j < D1_STEPS; j++) begin : g_div1
    localparam int B = D1_STEPS - 1 - j;
    div1_t nxt;
    if (j == 0) begin : g_first
      assign d1_src[j] = d1_in;
    end else begin : g_rest
      assign d1_src[j] = d1[j-1];
    end
    always_comb begin
      nxt = d1_src[j];
      if ((d1_src[j].r >> B) >= D1_W'(d1_src[j].d)) begin
        nxt.r    = d1_src[j].r - (D1_W'(d1_src[j].d) << B);
        nxt.q[B] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) d1[j] <= nxt;
    end
  end

  // Stage 3: b5 = x1 + x2
  logic signed [27:0] q1_s;
  logic signed [27:0] x2_w;
  logic signed [28:0] s3_b5;
  logic               s3_fault;
  logic        [18:0] s3_up;

  assign q1_s = $signed({1'b0, d1[D1_STEPS-1].q});
  assign x2_w = d1[D1_STEPS-1].neg ? -q1_s : q1_s;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_b5    <= 29'($signed(d1[D1_STEPS-1].x1)) + 29'(x2_w);
      s3_fault <= d1[D1_STEPS-1].fault;
      s3_up    <= d1[D1_STEPS-1].up;
    end
  end

  // Stage 4: temperature and b6
  logic signed [28:0] b5p8;
  logic signed [24:0] tsh;
  logic signed [15:0] t_sat;
  logic signed [15:0] s4_t;
  logic signed [28:0] s4_b6;
  logic               s4_fault;
  logic        [18:0] s4_up;

  assign b5p8 = s3_b5 + 29'sd8;
  assign tsh  = b5p8[28:4];

  always_comb begin
    if (tsh > 25'sd32767) begin
      t_sat = 16'sd32767;
    end else if (tsh < -25'sd32768) begin
      t_sat = -16'sd32768;
    end else begin
      t_sat = tsh[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_t     <= t_sat;
      s4_b6    <= s3_b5 - 29'sd4000;
      s4_fault <= s3_fault;
      s4_up    <= s3_up;
    end
  end

  // Stage 5: b6^2, ac2*b6, ac3*b6
  logic signed [57:0] sq_full;
  logic signed [44:0] m2_w, m3_w;
  logic        [55:0] s5_sqp;
  logic signed [44:0] s5_m2, s5_m3;
  logic signed [15:0] s5_t;
  logic               s5_fault;
  logic        [18:0] s5_up;

  assign sq_full = s4_b6 * s4_b6;
  assign m2_w    = s4_b6 * ac2;
  assign m3_w    = s4_b6 * ac3;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_sqp   <= sq_full[55:0];
      s5_m2    <= m2_w;
      s5_m3    <= m3_w;
      s5_t     <= s4_t;
      s5_fault <= s4_fault;
      s5_up    <= s4_up;
    end
  end

  // Stage 6: b3, ac3 term, split product b1*sq
  logic        [43:0] sq;
  logic signed [35:0] x3a;
  logic signed [36:0] b3i;
  logic signed [37:0] s6_b3;
  logic signed [31:0] s6_x1b;
  logic        [33:0] s6_ph;
  logic        [35:0] s6_pl;
  logic signed [15:0] s6_t;
  logic               s6_fault;
  logic        [18:0] s6_up;

  assign sq  = s5_sqp[55:12];
  assign x3a = $signed({1'b0, sq[43:9]}) + 36'($signed(s5_m2[44:11]));
  assign b3i = 37'(x3a) + 37'($signed({ac1, 2'b00}));

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_b3    <= $signed({b3i, 1'b0});
      s6_x1b   <= s5_m3[44:13];
      s6_ph    <= sq[43:23] * 13'd6190;
      s6_pl    <= sq[22:0] * 13'd6190;
      s6_t     <= s5_t;
      s6_fault <= s5_fault;
      s6_up    <= s5_up;
    end
  end

  // Stage 7: x2 = (b1*sq) >> 16, up - b3
  logic        [56:0] sum57;
  logic        [40:0] s7_x2b;
  logic signed [31:0] s7_x1b;
  logic signed [38:0] s7_diff;
  logic signed [15:0] s7_t;
  logic               s7_fault;

  assign sum57 = {s6_ph, 23'b0} + 57'(s6_pl);

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_x2b   <= sum57[56:16];
      s7_x1b   <= s6_x1b;
      s7_diff  <= $signed({20'b0, s6_up}) - 39'(s6_b3);
      s7_t     <= s6_t;
      s7_fault <= s6_fault;
    end
  end

  // Stage 8: x3 + 32768
  logic signed [42:0] sx;
  logic signed [40:0] x3_w;
  logic signed [41:0] s8_v;
  logic signed [38:0] s8_diff;
  logic signed [15:0] s8_t;
  logic               s8_fault;

  assign sx   = 43'(s7_x1b) + $signed({2'b0, s7_x2b}) + 43'sd2;
  assign x3_w = sx[42:2];

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_v     <= 42'(x3_w) + 42'sd32768;
      s8_diff  <= s7_diff;
      s8_t     <= s7_t;
      s8_fault <= s7_fault;
    end
  end

  // Stage 9: split product ac4*v, b7 = (up - b3) * 6250
  logic signed [37:0] ph4_w;
  logic signed [51:0] b7_w;
  logic signed [37:0] s9_ph4;
  logic        [36:0] s9_pl4;
  logic signed [51:0] s9_b7;
  logic signed [15:0] s9_t;
  logic               s9_fault;

  assign ph4_w = $signed(s8_v[41:21]) * $signed({1'b0, ac4});
  assign b7_w  = s8_diff * 14'sd6250;

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_ph4   <= ph4_w;
      s9_pl4   <= s8_v[20:0] * ac4;
      s9_b7    <= b7_w;
      s9_t     <= s8_t;
      s9_fault <= s8_fault;
    end
  end

  // Stage 10: b4, dividend magnitude
  logic signed [59:0] b4f;
  logic signed [44:0] b4_w;
  logic               caseb_w;
  logic signed [52:0] n_w;
  logic signed [52:0] n_neg;
  logic        [52:0] s10_nabs;
  logic        [43:0] s10_b4;
  logic               s10_nneg;
  logic               s10_caseb;
  logic signed [15:0] s10_t;
  logic               s10_fault;

  assign b4f     = 60'($signed({s9_ph4, 21'b0})) + $signed({23'b0, s9_pl4});
  assign b4_w    = b4f[59:15];
  assign caseb_w = (s9_b7 >= 52'sd2147483648);
  assign n_w     = caseb_w ? 53'(s9_b7) : $signed({s9_b7, 1'b0});
  assign n_neg   = -n_w;

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_nabs  <= n_w[52] ? n_neg : n_w;
      s10_b4    <= b4_w[43:0];
      s10_nneg  <= n_w[52];
      s10_caseb <= caseb_w;
      s10_t     <= s9_t;
      s10_fault <= s9_fault | b4_w[44] | (b4_w == 45'sd0);
    end
  end

  // Stage 11: quotient overflow check against the 22-bit cap
  div2_t s11;

  always_ff @(posedge clk) begin
    if (adv) begin
      s11.r     <= s10_nabs;
      s11.q     <= '0;
      s11.d     <= s10_b4;
      s11.sat   <= (66'(s10_nabs) >= {s10_b4, 22'b0});
      s11.neg   <= s10_nneg;
      s11.caseb <= s10_caseb;
      s11.t     <= s10_t;
      s11.fault <= s10_fault;
    end
  end

  // Pressure divider: one quotient bit per stage, MSB first
  div2_t d2     [D2_STEPS];
  div2_t d2_src [D2_STEPS];

  for (genvar j = 0; j < D2_STEPS; j++) begin : g_div2
    localparam int B = D2_STEPS - 1 - j;
    div2_t nxt;
    if (j == 0) begin : g_first
      assign d2_src[j] = s11;
    end else begin : g_rest
      assign d2_src[j] = d2[j-1];
    end
    always_comb begin
      nxt = d2_src[j];
      if ((d2_src[j].r >> B) >= D2_W'(d2_src[j].d)) begin
        nxt.r    = d2_src[j].r - (D2_W'(d2_src[j].d) << B);
        nxt.q[B] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) d2[j] <= nxt;
    end
  end

  // Stage 12: signed pressure estimate, clamped to -2^21 .. 2^21-1
  logic        [21:0] qc;
  logic signed [23:0] qc_s;
  logic signed [23:0] p_raw;
  logic signed [21:0] p_cl;
  logic signed [21:0] s12_p;
  logic signed [15:0] s12_t;
  logic               s12_fault;

  assign qc   = d2[D2_STEPS-1].sat ? {D2_STEPS{1'b1}} : d2[D2_STEPS-1].q;
  assign qc_s = $signed({2'b0, qc});

  always_comb begin
    if (d2[D2_STEPS-1].caseb) begin
      p_raw = $signed({1'b0, qc, 1'b0});
    end else if (d2[D2_STEPS-1].neg) begin
      p_raw = -qc_s;
    end else begin
      p_raw = qc_s;
    end
    if (p_raw > 24'sd2097151) begin
      p_cl = 22'sd2097151;
    end else if (p_raw < -24'sd2097152) begin
      p_cl = -22'sd2097152;
    end else begin
      p_cl = p_raw[21:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s12_p     <= p_cl;
      s12_t     <= d2[D2_STEPS-1].t;
      s12_fault <= d2[D2_STEPS-1].fault;
    end
  end

  // Stage 13: (p>>8)^2 and -7357*p
  logic signed [13:0] pa;
  logic signed [27:0] aa_w;
  logic signed [35:0] m_w;
  logic        [26:0] s13_aa;
  logic signed [35:0] s13_m;
  logic signed [21:0] s13_p;
  logic signed [15:0] s13_t;
  logic               s13_fault;

  assign pa   = s12_p[21:8];
  assign aa_w = pa * pa;
  assign m_w  = s12_p * C_P1;

  always_ff @(posedge clk) begin
    if (adv) begin
      s13_aa    <= aa_w[26:0];
      s13_m     <= m_w;
      s13_p     <= s12_p;
      s13_t     <= s12_t;
      s13_fault <= s12_fault;
    end
  end

  // Stage 14: correction terms
  logic        [38:0] x1c_full;
  logic        [22:0] s14_x1c;
  logic signed [19:0] s14_x2c;
  logic signed [21:0] s14_p;
  logic signed [15:0] s14_t;
  logic               s14_fault;

  assign x1c_full = s13_aa * 12'd3038;

  always_ff @(posedge clk) begin
    if (adv) begin
      s14_x1c   <= x1c_full[38:16];
      s14_x2c   <= s13_m[35:16];
      s14_p     <= s13_p;
      s14_t     <= s13_t;
      s14_fault <= s13_fault;
    end
  end

  // Stage 15: final pressure, saturation, output register
  logic signed [24:0] csum;
  logic signed [22:0] pr_w;
  logic        [19:0] pr_sat;
  logic signed [15:0] o_t;
  logic        [19:0] o_pr;
  logic               o_fault;

  assign csum = $signed({2'b0, s14_x1c}) + 25'(s14_x2c) + 25'sd3791;
  assign pr_w = 23'(s14_p) + 23'($signed(csum[24:4]));

  always_comb begin
    if (pr_w < 23'sd0) begin
      pr_sat = '0;
    end else if (pr_w > 23'sd1048575) begin
      pr_sat = 20'hFFFFF;
    end else begin
      pr_sat = pr_w[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_t     <= s14_fault ? 16'sd0 : s14_t;
      o_pr    <= s14_fault ? 20'd0 : pr_sat;
      o_fault <= s14_fault;
    end
  end

  assign m_tdata = {3'b0, o_fault, o_pr, o_t};

`ifndef SYNTHESIS
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_fault |-> (o_t == 16'sd0) && (o_pr == 20'd0))
    else $error("fault result carries nonzero data");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted transfer not marked valid in first stage");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("valid bits moved while pipeline held");
`endif

endmodule

@@ tb/sv/barometric_pressure_compensation_checker.sv @@
// Watches both streams of the pressure compensation block, predicts every result
// from the live coefficient copy and compares. Depends on bpc_pkg register codes.
module barometric_pressure_compensation_checker
  import bpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          n_results,
  output int          n_faults
);

  typedef struct packed {
    logic        fault;
    logic [19:0] pres;
    logic [15:0] temp;
  } reading_t;

  logic [15:0] coef [8];
  reading_t    readings_due[$];

  // floor shift for signed values
  function automatic longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic reading_t compensate(logic [15:0] ut_raw, logic [18:0] up_raw);
    reading_t r;
    longint ac1, ac2, ac3, ac4, ac5, ac6, mc, md, ut, up;
    longint x1, x2, x3, b3, b4, b5, b6, b7, p, sq, t, pr;
    ac1 = longint'($signed(coef[REG_AC1]));
    ac2 = longint'($signed(coef[REG_AC2]));
    ac3 = longint'($signed(coef[REG_AC3]));
    ac4 = longint'(coef[REG_AC4]);
    ac5 = longint'(coef[REG_AC5]);
    ac6 = longint'(coef[REG_AC6]);
    mc  = longint'($signed(coef[REG_MC]));
    md  = longint'($signed(coef[REG_MD]));
    ut  = longint'(ut_raw);
    up  = longint'(up_raw);
    r = '{fault: 1'b1, pres: '0, temp: '0};
    x1 = fshr((ut - ac6) * ac5, 15);
    if (x1 + md == 0) return r;
    x2 = (mc * 2048) / (x1 + md);
    b5 = x1 + x2;
    t = clip(fshr(b5 + 8, 4), -32768, 32767);
    b6 = b5 - 4000;
    sq = fshr(b6 * b6, 12);
    x1 = fshr(4 * sq, 11);
    x2 = fshr(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = fshr((ac1 * 4 + x3) * 8 + 2, 2);
    x1 = fshr(ac3 * b6, 13);
    x2 = fshr(6190 * sq, 16);
    x3 = fshr(x1 + x2 + 2, 2);
    b4 = fshr(ac4 * (x3 + 32768), 15);
    if (b4 <= 0) return r;
    b7 = (up - b3) * 6250;
    if (b7 < 64'sh8000_0000) p = (b7 * 2) / b4;
    else p = (b7 / b4) * 2;
    p = clip(p, -2097152, 2097151);
    x1 = fshr(p, 8) * fshr(p, 8);
    x1 = fshr(x1 * 3038, 16);
    x2 = fshr(-7357 * p, 16);
    pr = clip(p + fshr(x1 + x2 + 3791, 4), 0, 1048575);
    r.fault = 1'b0;
    r.temp  = t[15:0];
    r.pres  = pr[19:0];
    return r;
  endfunction

  assign pending = readings_due.size();

  always @(posedge clk) begin
    reading_t want, got;
    if (rst) begin
      coef[REG_AC1] <= 16'd408;
      coef[REG_AC2] <= -16'sd72;
      coef[REG_AC3] <= -16'sd14383;
      coef[REG_AC4] <= 16'd32741;
      coef[REG_AC5] <= 16'd32757;
      coef[REG_AC6] <= 16'd23153;
      coef[REG_MC]  <= -16'sd8711;
      coef[REG_MD]  <= 16'd2868;
      readings_due.delete();
      errors    <= 0;
      n_results <= 0;
      n_faults  <= 0;
    end else begin
      if (cfg_we) coef[cfg_index] <= cfg_data;
      // input transfer: predict from current coefficients
      if (s_tvalid && s_tready)
        readings_due.push_back(compensate(s_tdata[15:0], s_tdata[34:16]));
      // output transfer: compare against oldest prediction
      if (m_tvalid && m_tready) begin
        got = m_tdata[36:0];
        n_results <= n_results + 1;
        if (readings_due.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = readings_due.pop_front();
          if (want.fault) n_faults <= n_faults + 1;
          if (got !== want || m_tdata[39:37] !== 3'b0) begin
            $display("%0t: mismatch expected t=%0d p=%0d f=%0d actual t=%0d p=%0d f=%0d",
                     $time, $signed(want.temp), want.pres, want.fault,
                     $signed(got.temp), got.pres, got.fault);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/barometric_pressure_compensation_test.sv @@
// Stimulus and verdict for the pressure compensation block; the checker module
// does all prediction. Depends on bpc_pkg, the block and the checker.
module barometric_pressure_compensation_test;
  import bpc_pkg::*;

  localparam int LATENCY   = 65;
  localparam int MAX_CYCLE = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_AC1;
  logic [15:0] cfg_data = '0;
  int          errors, pending, n_results, n_faults;
  int          cycle = 0;
  int          stall_mode = 0;
  logic [15:0] calib [8];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  barometric_pressure_compensation u_top (.*);

  barometric_pressure_compensation_checker u_chk (.*);

  // run watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("barometric_pressure_compensation verification failed");
      $finish;
    end
  end

  // receiver stall pattern, changing character now and then
  always @(posedge clk) begin
    if (!rst && $urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 1) == 0);
      default: m_tready <= (cycle[3:0] < 4'd5);
    endcase
  end

  // one reading transfer, then maybe a gap
  task automatic send_reading(logic [15:0] ut, logic [18:0] up);
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, up, ut};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if ($urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // one register write; the caller drops the enable after the last one
  task automatic write_coef(logic [2:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    calib[idx] = val;
    @(posedge clk);
  endtask

  task automatic load_calib;
    for (int i = 0; i < 8; i++) write_coef(3'(i), calib[i]);
    cfg_we <= 1'b0;
  endtask

  // realistic raw reading around the calibration: ut mostly near ac6, random up
  task automatic random_readings(int count);
    logic [15:0] ut;
    logic [18:0] up;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1: ut = 16'($urandom);
        default: ut = 16'(calib[REG_AC6] + $urandom_range(0, 12000) - 6000);
      endcase
      case ($urandom_range(0, 9))
        0: up = 19'($urandom_range(0, 15));
        1: up = 19'h7FFFF - 19'($urandom_range(0, 15));
        default: up = 19'($urandom);
      endcase
      send_reading(ut, up);
    end
  endtask

  initial begin
    int per_phase;
    calib = '{16'd408, -16'sd72, -16'sd14383, 16'd32741, 16'd32757, 16'd23153,
              -16'sd8711, 16'd2868};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes and the nominal datasheet point
    send_reading(16'd27898, 19'd23843 << 3);
    send_reading(16'h0000, 19'h00000);
    send_reading(16'hFFFF, 19'h7FFFF);
    send_reading(16'h0000, 19'h7FFFF);
    send_reading(16'hFFFF, 19'h00000);
    send_reading(16'hAAAA, 19'h55555);
    send_reading(16'h5555, 19'h2AAAA);
    // zero temperature divisor: ac5=32768, ac6=0, md=-40 -> x1+md==0 at ut=40
    drain();
    repeat (LATENCY) @(posedge clk);
    calib = '{16'd408, -16'sd72, -16'sd14383, 16'd32741, 16'd32768, 16'd0,
              -16'sd1000, -16'sd40};
    load_calib();
    send_reading(16'd40, 19'd1000);
    send_reading(16'd41, 19'd1000);
    // non-positive sensitivity: ac4=0
    drain();
    repeat (LATENCY) @(posedge clk);
    calib[REG_AC4] = 16'd0;
    load_calib();
    send_reading(16'd30000, 19'd300000);
    drain();
    repeat (LATENCY) @(posedge clk);
    // extremes of every coefficient
    calib = '{16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'h8000, 16'h8000};
    load_calib();
    send_reading(16'hFFFF, 19'h7FFFF);
    send_reading(16'h0000, 19'h00000);
    send_reading(16'h1234, 19'h40000);
    drain();
    repeat (LATENCY) @(posedge clk);
    calib = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001, 16'h0000, 16'h0000,
              16'h7FFF, 16'h7FFF};
    load_calib();
    send_reading(16'hFFFF, 19'h7FFFF);
    send_reading(16'h0000, 19'h00000);
    send_reading(16'h8000, 19'h12345);

    // random phases: nominal set, then random sets, each fully drained
    per_phase = 190;
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      repeat (LATENCY) @(posedge clk);
      if (ph == 0)
        calib = '{16'd408, -16'sd72, -16'sd14383, 16'd32741, 16'd32757, 16'd23153,
                  -16'sd8711, 16'd2868};
      else if (ph % 3 == 0)
        for (int i = 0; i < 8; i++) calib[i] = 16'($urandom);
      else begin
        calib[REG_AC1] = 16'(408 + $urandom_range(0, 16000) - 8000);
        calib[REG_AC2] = 16'(-72 + $urandom_range(0, 2000) - 1000);
        calib[REG_AC3] = 16'(-14383 + $urandom_range(0, 8000) - 4000);
        calib[REG_AC4] = 16'(32741 + $urandom_range(0, 20000) - 10000);
        calib[REG_AC5] = 16'(32757 + $urandom_range(0, 20000) - 10000);
        calib[REG_AC6] = 16'($urandom);
        calib[REG_MC]  = 16'(-8711 + $urandom_range(0, 6000) - 3000);
        calib[REG_MD]  = 16'(2868 + $urandom_range(0, 2000) - 1000);
      end
      load_calib();
      // sender bursts with random gaps
      for (int done = 0; done < per_phase; ) begin
        int burst;
        burst = $urandom_range(1, 40);
        if (burst > per_phase - done) burst = per_phase - done;
        random_readings(burst);
        done += burst;
        if ($urandom_range(0, 2) == 0) begin
          s_tvalid <= 1'b0;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end
        if (ph == 4 && done < 40) begin
          s_tvalid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
    end

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    $display("Ran %0d readings over 13 calibration sets, %0d of them faulted.",
             n_results, n_faults);
    if (errors == 0)
      $display("barometric_pressure_compensation verification clean");
    else
      $display("barometric_pressure_compensation verification failed");
    $finish;
  end

endmodule
